[rtl/tra_pkg.sv]
// Package for the triggered record averager: constants and shared types.
`timescale 1ns / 1ps
package tra_pkg;
  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int MAX_RECORD_LEN_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_COMPARE_MODE = 2'd0,
    REG_TRIGGER_THRESHOLD = 2'd1,
    REG_RECORD_LENGTH = 2'd2,
    REG_AVERAGE_COUNT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_GT = 2'd1,
    CMP_LT = 2'd2,
    CMP_NEVER = 2'd3
  } cmp_mode_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_SKIP = 2'd1,
    PH_REC = 2'd2
  } phase_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;
endpackage

[rtl/triggered_record_averager.sv]
// Top level of the triggered record averager: capture, history ring and averaging.
`timescale 1ns / 1ps
// Samples pass through a trigger and are recorded into a ring of HISTORY_DEPTH
// records held in one single-port memory; averages live in a second memory.
// A push that does not end a record is accepted, then the result is offered,
// and the input stays stalled until the result is taken.
// A read passes through S_RDAVG and S_OUT, because the average memory read is registered.
// A push that ends a record with too few records in the ring is answered from
// the idle state, and one whose records are too short from the check state S_CHECK.
// Any other record end starts an averaging pass: the check, then for every position
// average_count history reads, each through S_ACC and S_ACCW, and a bit-serial
// divide by average_count. No clearing pass is needed after reset.
module triggered_record_averager #(
  parameter int HISTORY_DEPTH = tra_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_RECORD_LEN = tra_pkg::MAX_RECORD_LEN_DEF,
  parameter int SAMPLE_BITS = tra_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_opcode,
  input  logic [15:0] in_sample_value,
  input  logic in_column_odd,
  input  logic [9:0] in_read_index,
  output logic out_valid,
  input  logic out_stall,
  output logic [15:0] out_read_value,
  output logic out_read_valid,
  output logic out_record_done,
  output logic [1:0] out_capture_phase,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [tra_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import tra_pkg::*;

  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int PW = $clog2(MAX_RECORD_LEN);
  localparam int CW = PW + 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = SAMPLE_BITS + 4;
  localparam int DEPTH = HISTORY_DEPTH * (1 << PW);
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_RDAVG, S_CHECK, S_ACC, S_ACCW, S_DIV, S_OUT
  } st_t;

  logic [1:0]  cmp_r;
  logic [15:0] thr_r;
  logic [10:0] rlen_r;
  logic [3:0]  acnt_r;

  logic [15:0] hmem [DEPTH];
  logic [15:0] amem [MAX_RECORD_LEN];
  logic [CW-1:0] hlen [HISTORY_DEPTH];

  st_t st_r;
  phase_t ph_r;
  logic [CW-1:0] ccount_r;
  logic [HW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [CW-1:0] alen_r;

  logic [15:0] ov_val_r;
  logic ov_rv_r, ov_done_r;
  logic [1:0] ov_ph_r;
  logic out_valid_r;

  logic [9:0] ridx_r;
  logic [CW-1:0] len_r;
  logic [3:0] avg_r;
  logic [CW-1:0] pos_r;
  logic [3:0] k_r;
  logic [HW-1:0] slot_r;
  logic [SW-1:0] sum_r;
  logic [SW-1:0] rem_r;
  logic [4:0] dbit_r;
  logic hvld_r;
  logic [15:0] hrd_r, ard_r;

  logic hwe;
  logic [AW-1:0] haddr;
  logic [15:0] hwd;
  logic [PW-1:0] aaddr;
  logic [15:0] awd;
  logic awe;

  // config
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[3:2])
      REG_COMPARE_MODE: cfg_prdata = {30'd0, cmp_r};
      REG_TRIGGER_THRESHOLD: cfg_prdata = {16'd0, thr_r};
      REG_RECORD_LENGTH: cfg_prdata = {21'd0, rlen_r};
      REG_AVERAGE_COUNT: cfg_prdata = {28'd0, acnt_r};
      default: cfg_prdata = 32'd0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_r <= CMP_NEVER;
      thr_r <= 16'd0;
      rlen_r <= 11'd1024;
      acnt_r <= 4'd1;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      case (cfg_paddr[3:2])
        REG_COMPARE_MODE: cmp_r <= cfg_pwdata[1:0];
        REG_TRIGGER_THRESHOLD: thr_r <= cfg_pwdata[15:0];
        REG_RECORD_LENGTH: rlen_r <= cfg_pwdata[10:0];
        REG_AVERAGE_COUNT: acnt_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // effective length
  logic [CW-1:0] eff_len;
  always_comb begin
    if (rlen_r == 11'd0) eff_len = CW'(1);
    else if ({21'd0, rlen_r} > 32'(MAX_RECORD_LEN)) eff_len = CW'(MAX_RECORD_LEN);
    else eff_len = CW'(rlen_r);
  end
  logic [3:0] eff_avg;
  assign eff_avg = (acnt_r == 4'd0) ? 4'd1 : acnt_r;

  logic hit;
  logic [SAMPLE_BITS-1:0] smp;
  assign smp = in_sample_value[SAMPLE_BITS-1:0];
  always_comb begin
    case (cmp_r)
      CMP_EQ: hit = (16'(smp) == thr_r);
      CMP_GT: hit = (16'(smp) > thr_r);
      CMP_LT: hit = (16'(smp) < thr_r);
      default: hit = 1'b0;
    endcase
  end

  logic accept;
  assign in_stall = (st_r != S_IDLE) || out_valid_r;
  assign accept = in_valid && !in_stall;

  // slot of k-th newest record
  function automatic logic [HW-1:0] back_slot(input logic [HW-1:0] h, input logic [3:0] k);
    logic [HW+4:0] t;
    t = (HW+5)'(h) + (HW+5)'(HISTORY_DEPTH) - (HW+5)'(1) - (HW+5)'(k);
    if (t >= (HW+5)'(HISTORY_DEPTH)) t = t - (HW+5)'(HISTORY_DEPTH);
    return HW'(t);
  endfunction

  logic [CW-1:0] cnt_inc;
  assign cnt_inc = (ccount_r < CW'(MAX_RECORD_LEN)) ? ccount_r + 1'b1 : ccount_r;
  logic [PW-1:0] wpos;
  assign wpos = (ccount_r >= CW'(MAX_RECORD_LEN)) ? PW'(MAX_RECORD_LEN - 1)
                                                  : ccount_r[PW-1:0];
  logic [HW-1:0] cur_slot;
  assign cur_slot = back_slot(head_r, k_r);
  logic check_ok;
  always_comb begin
    check_ok = 1'b1;
    for (int k = 0; k < 16; k++)
      if (k < int'(avg_r) && hlen[back_slot(head_r, 4'(k))] < len_r) check_ok = 1'b0;
  end

  // memory port control
  always_comb begin
    hwe = 1'b0;
    hwd = 16'(smp);
    haddr = AW'({head_r, wpos});
    if (HISTORY_DEPTH == 1) haddr = AW'(wpos);
    if (accept && in_opcode == OP_PUSH && ph_r == PH_REC) hwe = 1'b1;
    if (st_r == S_ACC) begin
      haddr = AW'({cur_slot, pos_r[PW-1:0]});
      if (HISTORY_DEPTH == 1) haddr = AW'(pos_r[PW-1:0]);
    end
    aaddr = (st_r == S_DIV) ? pos_r[PW-1:0] : PW'(ridx_r);
    awe = (st_r == S_DIV) && (dbit_r == 5'd0);
    awd = 16'({rem_r[SW-2:0], sum_r[SW-1]} >= SW'(avg_r) ?
              {sum_r[SW-2:0], 1'b1} : {sum_r[SW-2:0], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (hwe) hmem[haddr] <= hwd;
    hrd_r <= hmem[haddr];
  end
  always_ff @(posedge clk) begin
    if (awe) amem[aaddr] <= awd;
    ard_r <= amem[aaddr];
  end

  logic [SW-1:0] trial;
  assign trial = {rem_r[SW-2:0], sum_r[SW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ph_r <= PH_WAIT;
      ccount_r <= '0;
      head_r <= '0;
      fill_r <= '0;
      alen_r <= '0;
      out_valid_r <= 1'b0;
      hvld_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      hvld_r <= (st_r == S_ACC);
      case (st_r)
        S_IDLE: if (accept) begin
          ov_val_r <= 16'd0;
          ov_rv_r <= 1'b0;
          ov_done_r <= 1'b0;
          if (in_opcode == OP_READ) begin
            ridx_r <= in_read_index;
            ov_ph_r <= ph_r;
            st_r <= S_RDAVG;
          end else if (ph_r == PH_REC) begin
            if (cnt_inc >= eff_len) begin
              hlen[head_r] <= cnt_inc;
              head_r <= (32'(head_r) == HISTORY_DEPTH - 1) ? '0 : head_r + 1'b1;
              if (fill_r < FW'(HISTORY_DEPTH)) fill_r <= fill_r + 1'b1;
              ccount_r <= '0;
              ph_r <= PH_WAIT;
              ov_ph_r <= PH_WAIT;
              ov_done_r <= 1'b1;
              len_r <= eff_len;
              avg_r <= eff_avg;
              if (32'(fill_r) + 1 > HISTORY_DEPTH ? 0 :
                  (32'(fill_r) + 1 < 32'(eff_avg))) begin
                alen_r <= '0;
                out_valid_r <= 1'b1;
              end else if (32'(eff_avg) > HISTORY_DEPTH) begin
                alen_r <= '0;
                out_valid_r <= 1'b1;
              end else st_r <= S_CHECK;
            end else begin
              ccount_r <= cnt_inc;
              ov_ph_r <= PH_REC;
              out_valid_r <= 1'b1;
            end
          end else if (ph_r == PH_SKIP) begin
            ph_r <= PH_REC;
            ov_ph_r <= PH_REC;
            out_valid_r <= 1'b1;
          end else begin
            if (hit) begin
              ph_r <= in_column_odd ? PH_REC : PH_SKIP;
              ov_ph_r <= in_column_odd ? PH_REC : PH_SKIP;
              ccount_r <= '0;
            end else ov_ph_r <= PH_WAIT;
            out_valid_r <= 1'b1;
          end
        end
        S_RDAVG: st_r <= S_OUT;
        S_OUT: begin
          if (alen_r != '0 && CW'(ridx_r) < alen_r) begin
            ov_val_r <= ard_r;
            ov_rv_r <= 1'b1;
          end
          out_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_CHECK: begin
          if (!check_ok) begin
            alen_r <= '0;
            out_valid_r <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            pos_r <= '0;
            k_r <= '0;
            sum_r <= '0;
            st_r <= S_ACC;
          end
        end
        S_ACC: st_r <= S_ACCW;
        S_ACCW: if (hvld_r) begin
          sum_r <= sum_r + SW'(hrd_r[SAMPLE_BITS-1:0]);
          if (k_r + 1'b1 == avg_r) begin
            k_r <= '0;
            rem_r <= '0;
            dbit_r <= 5'(SW);
            st_r <= S_DIV;
          end else begin
            k_r <= k_r + 1'b1;
            st_r <= S_ACC;
          end
        end
        S_DIV: begin
          if (dbit_r == 5'd0) begin
            if (pos_r + 1'b1 == len_r) begin
              alen_r <= len_r;
              out_valid_r <= 1'b1;
              st_r <= S_IDLE;
            end else begin
              pos_r <= pos_r + 1'b1;
              sum_r <= '0;
              st_r <= S_ACC;
            end
          end else begin
            dbit_r <= dbit_r - 1'b1;
            if (dbit_r != 5'd1) begin
              if (trial >= SW'(avg_r)) begin
                rem_r <= trial - SW'(avg_r);
                sum_r <= {sum_r[SW-2:0], 1'b1};
              end else begin
                rem_r <= trial;
                sum_r <= {sum_r[SW-2:0], 1'b0};
              end
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_read_value = ov_val_r;
  assign out_read_valid = ov_rv_r;
  assign out_record_done = ov_done_r;
  assign out_capture_phase = ov_ph_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_push_novalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_done) |-> !out_read_valid) else $error("done with read");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= HISTORY_DEPTH) else $error("fill overflow");
endmodule
